// ----- hw/rtl/vsrr_pkg.sv -----
// ---------------------------------------------------------------------------
// vsrr_pkg: shared types and constants for the vertical scroll row refill
// Microcode word layout, the sequencer program and fixed constants.
// ---------------------------------------------------------------------------
package vsrr_pkg;

   // VRAM ring geometry (fixed)
   localparam int RING_ROWS = 32;
   localparam int RING_W    = 5;

   // Ring row codes: a fill code below FILL_SPLIT draws the same map row,
   // codes at or above it draw the rows just above the camera.
   localparam logic [RING_W-1:0] ROW_NEAR   = 5'd29;  // scroll down: row below view
   localparam logic [RING_W-1:0] ROW_FAR    = 5'd30;  // scroll up: row above view
   localparam logic [RING_W-1:0] FILL_SPLIT = 5'd30;

   // Divide by tile height as multiply by a rounded-up reciprocal.
   localparam int DIV_SHIFT = 20;
   localparam int RECIP_W   = 21;
   localparam int CAM_MAG_W = 13;   // |camera_y| stays below 2**13

   // Register indexes
   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   localparam int STEP_W = 4;

   typedef enum logic [STEP_W-1:0] {
      ST_IDLE   = 4'd0,
      ST_DECODE = 4'd1,
      ST_CLAMP  = 4'd2,
      ST_TILE   = 4'd3,
      ST_CROSS  = 4'd4,
      ST_DIV    = 4'd5,
      ST_QUOT   = 4'd6,
      ST_SELECT = 4'd7,
      ST_RANGE  = 4'd8,
      ST_EMIT   = 4'd9
   } step_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_YMAX,
      OP_CLAMP,
      OP_TILE,
      OP_DIV,
      OP_QUOT,
      OP_SELECT,
      OP_BASE,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_WAIT_REQ,
      C_IF_FILL,
      C_IF_FLAT,
      C_IF_OUTSIDE,
      C_EMIT_LOOP
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ucode_type;

   // Sequencer program
   function automatic ucode_type ucode(input step_type s);
      ucode_type w;
      case (s)
         ST_IDLE:   w = '{op: OP_NONE,   cond: C_WAIT_REQ,   target: ST_DECODE};
         ST_DECODE: w = '{op: OP_YMAX,   cond: C_IF_FILL,    target: ST_DIV};
         ST_CLAMP:  w = '{op: OP_CLAMP,  cond: C_NEXT,       target: ST_IDLE};
         ST_TILE:   w = '{op: OP_TILE,   cond: C_NEXT,       target: ST_IDLE};
         ST_CROSS:  w = '{op: OP_NONE,   cond: C_IF_FLAT,    target: ST_IDLE};
         ST_DIV:    w = '{op: OP_DIV,    cond: C_NEXT,       target: ST_IDLE};
         ST_QUOT:   w = '{op: OP_QUOT,   cond: C_NEXT,       target: ST_IDLE};
         ST_SELECT: w = '{op: OP_SELECT, cond: C_NEXT,       target: ST_IDLE};
         ST_RANGE:  w = '{op: OP_BASE,   cond: C_IF_OUTSIDE, target: ST_IDLE};
         ST_EMIT:   w = '{op: OP_EMIT,   cond: C_EMIT_LOOP,  target: ST_IDLE};
         default:   w = '{op: OP_NONE,   cond: C_NEXT,       target: ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ----- hw/rtl/vertical_scroll_row_refill.sv -----
// ---------------------------------------------------------------------------
// vertical_scroll_row_refill: tile-map vertical scroll with VRAM row ring
// Moves clamp the camera and update the scroll byte; a tile-boundary crossing
// or a fill request emits one map row of tile writes if the row is in the map.
// ---------------------------------------------------------------------------
//
//  channel | ports                          | direction | transaction
//  --------+--------------------------------+-----------+--------------------------
//  req     | req_valid/req_stall + fields   | in        | one move or fill command
//  rsp     | rsp_valid/rsp_stall + fields   | out       | one VRAM tile write
//  csr     | psel/penable/pwrite/paddr/...  | in/out    | map_width @0, map_height @4
//
//  Move without crossing: steps DECODE, CLAMP, TILE and CROSS, then idle again.
//  Move with crossing: setup steps DECODE to RANGE, then ROW_TILES writes, one per cycle.
//  Fill: setup steps DECODE, DIV, QUOT, SELECT, RANGE, then ROW_TILES writes, one per cycle.
//  The write step sets the rate: one tile write per cycle through the output
//  register; rsp_stall holds the write step. req is taken only in idle.
//  Reset (synchronous) clears camera_y, scroll byte and both map registers.
//
module vertical_scroll_row_refill
   import vsrr_pkg::*;
#(
   parameter int ROW_TILES   = 28,
   parameter int VIEW_ROWS   = 28,
   parameter int TILE_PIXELS = 8
) (
   input  logic               clock,
   input  logic               reset,

   // command transactions
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic signed [15:0] req_target_y,
   input  logic [4:0]         req_fill_row,

   // tile write transactions
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_vram_column,
   output logic [4:0]         rsp_vram_row,
   output logic [15:0]        rsp_map_cell,
   output logic               rsp_last_write,

   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // ceil(2**DIV_SHIFT / TILE_PIXELS); exact quotients for |x| < 2**13
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((2**DIV_SHIFT + TILE_PIXELS - 1) / TILE_PIXELS);
   localparam logic signed [15:0] TILE_S = 16'(TILE_PIXELS);
   localparam logic [8:0]         VIEW_U = 9'(VIEW_ROWS);
   localparam logic [5:0]         LAST_COL = 6'(ROW_TILES - 1);
   localparam int                 BP_W = 8 + RECIP_W;
   localparam int                 CP_W = CAM_MAG_W + RECIP_W;

   // ---- sequencer ---------------------------------------------------------
   step_type  step_ff, step_in, step_seq;
   ucode_type uc;

   // ---- registers ---------------------------------------------------------
   logic [7:0]         map_width_ff, map_height_ff;
   logic signed [15:0] camera_y_ff, camera_y_in;
   logic [7:0]         scroll_ff, scroll_in;
   logic [7:0]         prev_ff, prev_in;

   logic               mode_ff;
   logic signed [15:0] target_ff;
   logic [4:0]         fill_ff;

   logic signed [15:0] ymax_ff, ymax_in;
   logic               flat_ff, flat_in;
   logic               up_ff, up_in;
   logic               neg_ff, neg_in;
   logic [CP_W-1:0]    prod_ff, prod_in;
   logic signed [15:0] ct_ff, ct_in;
   logic [RING_W-1:0]  ring_ff, ring_in;
   logic signed [15:0] mrow_ff, mrow_in;
   logic [15:0]        cell_ff, cell_in;
   logic [5:0]         col_ff, col_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [5:0]         rsp_col_ff;
   logic [4:0]         rsp_row_ff;
   logic [15:0]        rsp_cell_ff;
   logic               rsp_last_ff;

   // ---- handshakes --------------------------------------------------------
   logic req_fire, emit_go, last_col, outside, csr_wr;

   assign req_stall = (step_ff != ST_IDLE);
   assign req_fire  = req_valid & ~req_stall;
   assign uc        = ucode(step_ff);
   assign emit_go   = (uc.op == OP_EMIT) & (~rsp_valid_ff | ~rsp_stall);
   assign last_col  = (col_ff == LAST_COL);
   // map row must lie in 0..map_height-1
   assign outside   = (mrow_ff < 16'sd0) | (mrow_ff >= $signed({8'd0, map_height_ff}));

   // ---- next step ---------------------------------------------------------
   always_comb begin
      step_seq = step_type'(STEP_W'(step_ff) + STEP_W'(1));
      case (uc.cond)
         C_NEXT:       step_in = step_seq;
         C_WAIT_REQ:   step_in = req_fire ? uc.target : step_ff;
         C_IF_FILL:    step_in = mode_ff ? uc.target : step_seq;
         C_IF_FLAT:    step_in = flat_ff ? uc.target : step_seq;
         C_IF_OUTSIDE: step_in = outside ? uc.target : step_seq;
         C_EMIT_LOOP:  step_in = (emit_go & last_col) ? uc.target : step_ff;
         default:      step_in = ST_IDLE;
      endcase
   end

   // ---- datapath driven by the control word -------------------------------
   logic [8:0]         h_diff;
   logic signed [15:0] h_diff_s;
   logic [BP_W-1:0]    prev_prod, new_prod;
   logic [7:0]         prev_tile, new_tile, up_dist, dn_dist;
   logic [15:0]        cam_abs;
   logic [CAM_MAG_W-1:0] quot;
   logic [4:0]         code;
   logic [5:0]         row_off;

   always_comb begin
      // defaults: hold
      camera_y_in = camera_y_ff;
      scroll_in   = scroll_ff;
      prev_in     = prev_ff;
      ymax_in     = ymax_ff;
      flat_in     = flat_ff;
      up_in       = up_ff;
      neg_in      = neg_ff;
      prod_in     = prod_ff;
      ct_in       = ct_ff;
      ring_in     = ring_ff;
      mrow_in     = mrow_ff;
      cell_in     = cell_ff;
      col_in      = col_ff;

      // ymax = (map_height - VIEW_ROWS) * TILE_PIXELS, may be negative
      h_diff    = {1'b0, map_height_ff} - VIEW_U;
      h_diff_s  = 16'($signed(h_diff));

      prev_prod = BP_W'(prev_ff) * BP_W'(RECIP);
      new_prod  = BP_W'(scroll_ff) * BP_W'(RECIP);
      prev_tile = prev_prod[DIV_SHIFT +: 8];
      new_tile  = new_prod[DIV_SHIFT +: 8];
      up_dist   = scroll_ff - prev_ff;
      dn_dist   = prev_ff - scroll_ff;

      cam_abs   = camera_y_ff[15] ? 16'(-camera_y_ff) : camera_y_ff;
      quot      = prod_ff[DIV_SHIFT +: CAM_MAG_W];

      // moves map onto fill codes: down scroll draws code 29, up draws 30
      code      = mode_ff ? fill_ff : (up_ff ? ROW_NEAR : ROW_FAR);
      // codes 30 and 31 reach back above the camera (offset code - 32)
      row_off   = (code < FILL_SPLIT) ? {1'b0, code} : {1'b1, code};

      case (uc.op)
         OP_YMAX: begin
            ymax_in = 16'(h_diff_s * TILE_S);
         end
         OP_CLAMP: begin
            if (target_ff < 16'sd0) begin
               camera_y_in = 16'sd0;
            end else if (target_ff > ymax_ff) begin
               camera_y_in = ymax_ff;
            end else begin
               camera_y_in = target_ff;
            end
            scroll_in = camera_y_in[7:0];
            prev_in   = scroll_ff;
         end
         OP_TILE: begin
            flat_in = (prev_tile == new_tile);
            up_in   = (up_dist < dn_dist);
         end
         OP_DIV: begin
            neg_in  = camera_y_ff[15];
            prod_in = CP_W'(cam_abs[CAM_MAG_W-1:0]) * CP_W'(RECIP);
         end
         OP_QUOT: begin
            // truncate toward zero
            ct_in = neg_ff ? -$signed(16'(quot)) : $signed(16'(quot));
         end
         OP_SELECT: begin
            ring_in = ct_ff[RING_W-1:0] + code;
            mrow_in = ct_ff + 16'($signed(row_off));
         end
         OP_BASE: begin
            cell_in = 16'(mrow_ff[7:0]) * 16'(map_width_ff);
            col_in  = 6'd0;
         end
         OP_EMIT: begin
            if (emit_go) begin
               cell_in = cell_ff + 16'd1;
               col_in  = col_ff + 6'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // output register: free when empty or being taken
   always_comb begin
      if (emit_go) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---- register port -----------------------------------------------------
   assign csr_wr = psel & penable & pwrite;
   assign pready = 1'b1;

   always_comb begin
      case (paddr[2])
         CSR_MAP_WIDTH:  prdata = {24'd0, map_width_ff};
         CSR_MAP_HEIGHT: prdata = {24'd0, map_height_ff};
         default:        prdata = 32'd0;
      endcase
   end

   // ---- control and architectural state -----------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         camera_y_ff   <= 16'sd0;
         scroll_ff     <= 8'd0;
         map_width_ff  <= 8'd0;
         map_height_ff <= 8'd0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         camera_y_ff  <= camera_y_in;
         scroll_ff    <= scroll_in;
         if (csr_wr && paddr[2] == CSR_MAP_WIDTH) begin
            map_width_ff <= pwdata[7:0];
         end
         if (csr_wr && paddr[2] == CSR_MAP_HEIGHT) begin
            map_height_ff <= pwdata[7:0];
         end
      end
   end

   // ---- payload registers -------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff   <= req_mode;
         target_ff <= req_target_y;
         fill_ff   <= req_fill_row;
      end
      prev_ff <= prev_in;
      ymax_ff <= ymax_in;
      flat_ff <= flat_in;
      up_ff   <= up_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      ct_ff   <= ct_in;
      ring_ff <= ring_in;
      mrow_ff <= mrow_in;
      cell_ff <= cell_in;
      col_ff  <= col_in;
      if (emit_go) begin
         rsp_col_ff  <= col_ff;
         rsp_row_ff  <= ring_ff;
         rsp_cell_ff <= cell_ff;
         rsp_last_ff <= last_col;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vram_column = rsp_col_ff;
   assign rsp_vram_row    = rsp_row_ff;
   assign rsp_map_cell    = rsp_cell_ff;
   assign rsp_last_write  = rsp_last_ff;

endmodule
